FILE: hdl/frwl_pkg.sv
// ----------------------------------------------------------------------------
// frwl_pkg - fixed window rate limiter shared definitions
// Field widths, register indexes, status codes and the structs passed
// between the limiter's modules.
// ----------------------------------------------------------------------------
package frwl_pkg;

    // payload field widths
    localparam int ENDPOINT_W  = 4;
    localparam int TIME_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 16;
    localparam int TOTAL_W     = 32;

    // configuration port
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // per-endpoint limit slots held in the register file
    localparam int LIMIT_SLOTS = 4;
    localparam int LIMIT_IDX_W = 2;

    localparam int ENDPOINT_COUNT_DEFAULT = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SECONDS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_0        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_1        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_2        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_3        = 3'd4;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] WINDOW_SECONDS_RST = 16'd60;
    localparam logic [CFG_DATA_W-1:0] LIMIT_0_RST        = 16'd50;
    localparam logic [CFG_DATA_W-1:0] LIMIT_1_RST        = 16'd100;
    localparam logic [CFG_DATA_W-1:0] LIMIT_2_RST        = 16'd200;
    localparam logic [CFG_DATA_W-1:0] LIMIT_3_RST        = 16'd0;

    // decision codes
    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOWED  = 2'd0,
        ST_EXCEEDED = 2'd1,
        ST_ERROR    = 2'd2
    } status_t;

    // live configuration seen by the decision logic
    typedef struct packed {
        logic [CFG_DATA_W-1:0]                  window_seconds;
        logic [LIMIT_SLOTS-1:0][CFG_DATA_W-1:0] limit;
    } cfg_t;

    // one decision
    typedef struct packed {
        status_t              status;
        logic [COUNT_W-1:0]   remaining;
        logic [TOTAL_W-1:0]   hits_total;
        logic [TOTAL_W-1:0]   exceeded_total;
    } result_t;

endpackage

FILE: hdl/frwl_if.sv
// ----------------------------------------------------------------------------
// frwl_if - fixed window rate limiter channel interfaces
// Request, response and configuration write channels, each a valid/ready
// handshake with its payload.
// ----------------------------------------------------------------------------

// request channel
interface frwl_req_if;
    import frwl_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ENDPOINT_W-1:0] endpoint;
    logic [TIME_W-1:0]     now_seconds;

    modport source (output valid, output endpoint, output now_seconds, input ready);
    modport sink   (input valid, input endpoint, input now_seconds, output ready);
endinterface

// response channel
interface frwl_rsp_if;
    import frwl_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  remaining;
    logic [TOTAL_W-1:0]  hits_total;
    logic [TOTAL_W-1:0]  exceeded_total;

    modport source (output valid, output status, output remaining, output hits_total,
                    output exceeded_total, input ready);
    modport sink   (input valid, input status, input remaining, input hits_total,
                    input exceeded_total, output ready);
endinterface

// configuration write channel
interface frwl_cfg_if;
    import frwl_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/frwl_cfg.sv
// ----------------------------------------------------------------------------
// frwl_cfg - configuration register file
// Holds the window length and the per-endpoint limits; one write per
// transfer, unknown indexes are dropped.
// ----------------------------------------------------------------------------
module frwl_cfg (
    input  logic          clk,
    input  logic          rst_n,
    frwl_cfg_if.sink      cfg,
    output frwl_pkg::cfg_t cfg_out
);
    import frwl_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // writes are always taken
    assign cfg.ready = 1'b1;
    assign cfg_out   = cfg_reg;

    // index decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_WINDOW_SECONDS: cfg_next.window_seconds = cfg.data;
                CFG_LIMIT_0:        cfg_next.limit[0]       = cfg.data;
                CFG_LIMIT_1:        cfg_next.limit[1]       = cfg.data;
                CFG_LIMIT_2:        cfg_next.limit[2]       = cfg.data;
                CFG_LIMIT_3:        cfg_next.limit[3]       = cfg.data;
                default:            cfg_next                = cfg_reg;
            endcase
        end
    end

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_seconds <= WINDOW_SECONDS_RST;
            cfg_reg.limit[0]       <= LIMIT_0_RST;
            cfg_reg.limit[1]       <= LIMIT_1_RST;
            cfg_reg.limit[2]       <= LIMIT_2_RST;
            cfg_reg.limit[3]       <= LIMIT_3_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: hdl/frwl_core.sv
// ----------------------------------------------------------------------------
// frwl_core - window state and per-request decision
// Holds the window start, the per-endpoint counts and the running totals,
// and turns one registered request into one decision combinationally.
// ----------------------------------------------------------------------------
module frwl_core #(
    parameter int ENDPOINT_COUNT = frwl_pkg::ENDPOINT_COUNT_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [frwl_pkg::ENDPOINT_W-1:0] endpoint,
    input  logic [frwl_pkg::TIME_W-1:0]     now_seconds,
    input  frwl_pkg::cfg_t                cfg,
    output frwl_pkg::result_t             result
);
    import frwl_pkg::*;

    localparam logic [ENDPOINT_W-1:0] EP_BOUND = ENDPOINT_W'(ENDPOINT_COUNT);

    logic [COUNT_W-1:0] counts_reg  [ENDPOINT_COUNT];
    logic [COUNT_W-1:0] counts_next [ENDPOINT_COUNT];
    logic [COUNT_W-1:0] counts_eff  [ENDPOINT_COUNT];
    logic [TIME_W-1:0]  start_reg;
    logic [TIME_W-1:0]  start_next;
    logic               open_reg;
    logic               open_next;
    logic [TOTAL_W-1:0] hits_reg;
    logic [TOTAL_W-1:0] hits_next;
    logic [TOTAL_W-1:0] exc_reg;
    logic [TOTAL_W-1:0] exc_next;

    logic [TIME_W-1:0]  elapsed;
    logic               new_window;
    logic               ep_ok;
    logic [COUNT_W-1:0] cur;
    logic [COUNT_W-1:0] cur_inc;
    logic [COUNT_W-1:0] lim;
    logic               over;
    logic               allow;

    // window expiry, elapsed time wraps modulo 2^32
    assign elapsed    = now_seconds - start_reg;
    assign new_window = !open_reg || (elapsed >= TIME_W'(cfg.window_seconds));
    assign ep_ok      = endpoint < EP_BOUND;

    // counts as seen after a possible window restart
    always_comb
    begin
        for (int i = 0; i < ENDPOINT_COUNT; i++)
        begin
            counts_eff[i] = new_window ? '0 : counts_reg[i];
        end
    end

    // select the addressed count and limit
    always_comb
    begin
        cur = '0;
        for (int i = 0; i < ENDPOINT_COUNT; i++)
        begin
            if (endpoint == ENDPOINT_W'(i))
            begin
                cur = counts_eff[i];
            end
        end
    end

    assign lim     = cfg.limit[endpoint[LIMIT_IDX_W-1:0]];
    assign over    = cur >= lim;
    assign allow   = ep_ok && !over;
    assign cur_inc = cur + COUNT_W'(1);

    // decision and totals
    always_comb
    begin
        hits_next = hits_reg;
        exc_next  = exc_reg;
        result.status    = ST_ERROR;
        result.remaining = '0;
        if (ep_ok)
        begin
            hits_next = hits_reg + TOTAL_W'(1);
            if (over)
            begin
                exc_next      = exc_reg + TOTAL_W'(1);
                result.status = ST_EXCEEDED;
            end
            else
            begin
                result.status    = ST_ALLOWED;
                result.remaining = lim - cur_inc;
            end
        end
        result.hits_total     = hits_next;
        result.exceeded_total = exc_next;
    end

    // next window state and counts
    always_comb
    begin
        start_next = new_window ? now_seconds : start_reg;
        open_next  = 1'b1;
        for (int i = 0; i < ENDPOINT_COUNT; i++)
        begin
            counts_next[i] = counts_eff[i];
            if (allow && (endpoint == ENDPOINT_W'(i)))
            begin
                counts_next[i] = cur_inc;
            end
        end
    end

    // state registers, updated once per processed request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            open_reg  <= 1'b0;
            hits_reg  <= '0;
            exc_reg   <= '0;
            for (int i = 0; i < ENDPOINT_COUNT; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            start_reg <= start_next;
            open_reg  <= open_next;
            hits_reg  <= hits_next;
            exc_reg   <= exc_next;
            for (int i = 0; i < ENDPOINT_COUNT; i++)
            begin
                counts_reg[i] <= counts_next[i];
            end
        end
    end

endmodule

FILE: hdl/fixed_window_rate_limiter.sv
// ----------------------------------------------------------------------------
// fixed_window_rate_limiter - fixed window request rate limiter
// Polices requests per endpoint against per-window limits and reports the
// decision with running hit and exceeded totals.
// ----------------------------------------------------------------------------
// Usage:
//   req  - request channel: endpoint number and current time in seconds.
//   rsp  - response channel: status, remaining, hits_total, exceeded_total,
//          exactly one response per request, in request order.
//   cfg  - register writes (window length, four limits), always ready;
//          write only while no request is in flight.
// Path: a request taken from req sits in the input register, is decided
//   and registered in the result register once that is free or being
//   emptied, and can be taken from rsp from then on.
// Throughput: one request per cycle unless rsp stalls; the window and count
//   state is read, decided on and rewritten within that one cycle.
// Reset: counts, totals and the window clear, no window is open, the
//   registers return to 60 s and limits 50, 100, 200 and 0.
// Stall: while rsp.ready is low the response holds; one further request
//   waits in the input register, after which req.ready drops.
// ----------------------------------------------------------------------------
module fixed_window_rate_limiter #(
    parameter int ENDPOINT_COUNT = frwl_pkg::ENDPOINT_COUNT_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    frwl_req_if.sink   req,
    frwl_rsp_if.source rsp,
    frwl_cfg_if.sink   cfg
);
    import frwl_pkg::*;

    cfg_t                  cfg_live;
    result_t               result;

    logic                  in_vld_reg;
    logic [ENDPOINT_W-1:0] in_ep_reg;
    logic [TIME_W-1:0]     in_now_reg;
    logic                  out_vld_reg;
    result_t               out_reg;
    logic                  step;

    // advance when the result slot is free or being emptied
    assign step      = in_vld_reg && (!out_vld_reg || rsp.ready);
    assign req.ready = !in_vld_reg || step;

    frwl_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_live)
    );

    frwl_core #(
        .ENDPOINT_COUNT (ENDPOINT_COUNT)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .endpoint    (in_ep_reg),
        .now_seconds (in_now_reg),
        .cfg         (cfg_live),
        .result      (result)
    );

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_vld_reg <= req.valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_ep_reg  <= req.endpoint;
            in_now_reg <= req.now_seconds;
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (step)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= result;
        end
    end

    assign rsp.valid          = out_vld_reg;
    assign rsp.status         = out_reg.status;
    assign rsp.remaining      = out_reg.remaining;
    assign rsp.hits_total     = out_reg.hits_total;
    assign rsp.exceeded_total = out_reg.exceeded_total;

endmodule

FILE: sim/tb_fixed_window_rate_limiter.sv
// ----------------------------------------------------------------------------
// tb_fixed_window_rate_limiter - testbench for the fixed window rate limiter
// Drives requests through a queue-fed driver, predicts every decision with a
// local copy of the window, counts and limits, and checks each response
// transfer field by field. Directed corner cases come first, then random
// phases under varying register settings and random back-pressure.
// ----------------------------------------------------------------------------
module tb_fixed_window_rate_limiter;
    import frwl_pkg::*;

    localparam int EP_COUNT      = ENDPOINT_COUNT_DEFAULT;
    localparam int IDLE_LIMIT    = 1000;
    localparam int HOLD_CYCLES   = 80;
    localparam int PHASE_ITEMS   = 225;
    localparam int RANDOM_PHASES = 8;

    typedef struct packed {
        logic [ENDPOINT_W-1:0] endpoint;
        logic [TIME_W-1:0]     now_seconds;
    } request_t;

    logic clk = 1'b0;
    logic rst_n;

    frwl_req_if req_ch ();
    frwl_rsp_if rsp_ch ();
    frwl_cfg_if cfg_ch ();

    fixed_window_rate_limiter #(
        .ENDPOINT_COUNT(EP_COUNT)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source),
        .cfg   (cfg_ch.sink)
    );

    always #6 clk = ~clk;

    // predicted limiter state and register copy
    logic [CFG_DATA_W-1:0] win_len;
    logic [CFG_DATA_W-1:0] limits [LIMIT_SLOTS];
    logic [COUNT_W-1:0]    ep_counts [LIMIT_SLOTS];
    logic [TIME_W-1:0]     win_start;
    logic                  win_open;
    logic [TOTAL_W-1:0]    hit_total;
    logic [TOTAL_W-1:0]    exceed_total;

    request_t pending_requests [$];
    result_t  expected_decisions [$];

    int mismatches = 0;
    int decisions_seen = 0;
    logic [TIME_W-1:0] stim_now = '0;

    // register copy at reset
    initial
    begin
        win_len   = WINDOW_SECONDS_RST;
        limits[0] = LIMIT_0_RST;
        limits[1] = LIMIT_1_RST;
        limits[2] = LIMIT_2_RST;
        limits[3] = LIMIT_3_RST;
        foreach (ep_counts[i]) ep_counts[i] = '0;
        win_start    = '0;
        win_open     = 1'b0;
        hit_total    = '0;
        exceed_total = '0;
    end

    // works out the decision for one request and advances the predicted state
    function automatic result_t decide_request(input logic [ENDPOINT_W-1:0] ep,
                                               input logic [TIME_W-1:0] now);
        result_t           r;
        logic [TIME_W-1:0] elapsed;
        elapsed = now - win_start;
        if (!win_open || elapsed >= {16'b0, win_len})
        begin
            win_start = now;
            win_open  = 1'b1;
            foreach (ep_counts[i]) ep_counts[i] = '0;
        end
        r.remaining = '0;
        if (int'(ep) >= EP_COUNT)
        begin
            r.status = ST_ERROR;
        end
        else
        begin
            hit_total = hit_total + 1;
            if (ep_counts[ep] >= limits[ep])
            begin
                exceed_total = exceed_total + 1;
                r.status = ST_EXCEEDED;
            end
            else
            begin
                ep_counts[ep] = ep_counts[ep] + COUNT_W'(1);
                r.remaining = limits[ep] - ep_counts[ep];
                r.status = ST_ALLOWED;
            end
        end
        r.hits_total     = hit_total;
        r.exceeded_total = exceed_total;
        return r;
    endfunction

    // gap length: mostly none or short, a few long, sometimes a quiet run
    function automatic int pick_gap(inout int quiet_left);
        int r;
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            quiet_left = $urandom_range(16, 64);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR: %s", msg);
        mismatches++;
    endtask

    // request driver
    int req_gap = 0;
    int req_quiet = 0;
    always @(posedge clk or negedge rst_n)
    begin
        request_t item;
        if (!rst_n)
        begin
            req_ch.valid       <= 1'b0;
            req_ch.endpoint    <= '0;
            req_ch.now_seconds <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                expected_decisions.push_back(decide_request(req_ch.endpoint,
                                                            req_ch.now_seconds));
            if (!req_ch.valid || req_ch.ready)
            begin
                if (req_gap > 0)
                begin
                    req_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    item = pending_requests.pop_front();
                    req_ch.valid       <= 1'b1;
                    req_ch.endpoint    <= item.endpoint;
                    req_ch.now_seconds <= item.now_seconds;
                    req_gap = pick_gap(req_quiet);
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // response monitor with random stalls and occasional long hold-off
    int rsp_stall = 0;
    int rsp_quiet = 0;
    int rsp_hold = 0;
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_decisions.size() == 0)
                begin
                    report_error($sformatf("response %0d with no request waiting",
                                           decisions_seen));
                end
                else
                begin
                    want = expected_decisions.pop_front();
                    if (rsp_ch.status !== want.status)
                        report_error($sformatf("response %0d status %0d, expected %0d",
                                               decisions_seen, rsp_ch.status, want.status));
                    if (rsp_ch.remaining !== want.remaining)
                        report_error($sformatf("response %0d remaining %0d, expected %0d",
                                               decisions_seen, rsp_ch.remaining,
                                               want.remaining));
                    if (rsp_ch.hits_total !== want.hits_total)
                        report_error($sformatf("response %0d hits_total %0d, expected %0d",
                                               decisions_seen, rsp_ch.hits_total,
                                               want.hits_total));
                    if (rsp_ch.exceeded_total !== want.exceeded_total)
                        report_error($sformatf("response %0d exceeded_total %0d, expected %0d",
                                               decisions_seen, rsp_ch.exceeded_total,
                                               want.exceeded_total));
                end
                decisions_seen++;
                if (decisions_seen == 100 || decisions_seen == 800 || decisions_seen == 1500)
                    rsp_hold = HOLD_CYCLES;
                rsp_stall = pick_gap(rsp_quiet);
            end
            if (rsp_hold > 0)
            begin
                rsp_hold--;
                rsp_ch.ready <= 1'b0;
            end
            else if (rsp_stall > 0)
            begin
                rsp_stall--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transfer
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (req_ch.valid && req_ch.ready) ||
            (rsp_ch.valid && rsp_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // one register write transfer; caller is at a rising edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        case (idx)
            CFG_WINDOW_SECONDS: win_len   = data;
            CFG_LIMIT_0:        limits[0] = data;
            CFG_LIMIT_1:        limits[1] = data;
            CFG_LIMIT_2:        limits[2] = data;
            CFG_LIMIT_3:        limits[3] = data;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] win,
                              input logic [CFG_DATA_W-1:0] l0,
                              input logic [CFG_DATA_W-1:0] l1,
                              input logic [CFG_DATA_W-1:0] l2,
                              input logic [CFG_DATA_W-1:0] l3);
        write_reg(CFG_WINDOW_SECONDS, win);
        write_reg(CFG_LIMIT_0, l0);
        write_reg(CFG_LIMIT_1, l1);
        write_reg(CFG_LIMIT_2, l2);
        write_reg(CFG_LIMIT_3, l3);
        cfg_ch.valid <= 1'b0;
    endtask

    // waits until every request is decided and the pipeline is empty
    task automatic drain;
        while (pending_requests.size() != 0 || req_ch.valid || expected_decisions.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic add(input logic [ENDPOINT_W-1:0] ep, input logic [TIME_W-1:0] t);
        request_t item;
        item.endpoint    = ep;
        item.now_seconds = t;
        pending_requests.push_back(item);
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_limit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return CFG_DATA_W'($urandom_range(0, 12));
        if (r < 85) return CFG_DATA_W'($urandom_range(13, 300));
        if (r < 92) return '0;
        if (r < 96) return 16'hFFFF;
        return CFG_DATA_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_window();
        case ($urandom_range(0, 5))
            0: return 16'd1;
            1: return 16'hFFFF;
            2: return CFG_DATA_W'($urandom_range(2, 10));
            3: return 16'd60;
            4: return CFG_DATA_W'($urandom_range(11, 500));
            default: return CFG_DATA_W'($urandom_range(1, 65535));
        endcase
    endfunction

    // random traffic, some to bad endpoints: time mostly stands or creeps, sometimes jumps
    task automatic add_random_requests(input int n);
        int r;
        logic [ENDPOINT_W-1:0] ep;
        ep = '0;
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)      ;
            else if (r < 85) stim_now = stim_now + 1;
            else if (r < 91) stim_now = stim_now + TIME_W'(win_len);
            else if (r < 95) stim_now = stim_now - $urandom_range(1, 100);
            else if (r < 98) stim_now = $urandom();
            else             stim_now = stim_now + $urandom_range(0, 3 * win_len);
            r = $urandom_range(0, 99);
            if (r < 15)      ep = ENDPOINT_W'($urandom_range(EP_COUNT, 15));
            else if (r < 60) ep = ENDPOINT_W'($urandom_range(0, EP_COUNT - 1));
            else if (int'(ep) >= EP_COUNT) ep = ENDPOINT_W'($urandom_range(0, EP_COUNT - 1));
            add(ep, stim_now);
        end
    endtask

    // stimulus sequence
    initial
    begin
        logic [CFG_IDX_W-1:0] idx;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data  <= '0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: first window at time zero, zero limit, bad endpoints,
        // window edge, restart on a bad endpoint, time going back, time wrap
        add(4'd0, 32'd0);
        add(4'd3, 32'd5);
        add(4'd7, 32'd10);
        add(4'd15, 32'd59);
        add(4'd0, 32'd59);
        add(4'd0, 32'd60);
        add(4'd9, 32'd200);
        add(4'd0, 32'd201);
        add(4'd1, 32'd100);
        add(4'd2, 32'hFFFF_FFF0);
        add(4'd2, 32'h0000_0005);
        add(4'd1, 32'hFFFF_FFFF);
        drain();

        // zero window length: every request restarts the window
        set_config(16'd0, 16'd1, 16'd100, 16'd200, 16'd0);
        add(4'd0, 32'd7);
        add(4'd0, 32'd7);
        add(4'd0, 32'd7);
        add(4'd3, 32'd7);
        drain();

        // longest window, largest limit, limit reached
        set_config(16'hFFFF, 16'd2, 16'hFFFF, 16'd1, 16'd3);
        add(4'd0, 32'd1000);
        add(4'd0, 32'd1000);
        add(4'd0, 32'd1000);
        add(4'd1, 32'd1000);
        add(4'd2, 32'd66534);
        drain();

        // limit lowered below the count, then a fresh window; stray indexes ignored
        write_reg(CFG_LIMIT_0, 16'd1);
        idx = CFG_LIMIT_3;
        repeat (3)
        begin
            idx++;
            write_reg(idx, 16'hFFFF);
        end
        cfg_ch.valid <= 1'b0;
        add(4'd0, 32'd1001);
        add(4'd2, 32'd66535);
        add(4'd0, 32'd66535);
        drain();

        // random phases under random settings
        stim_now = 32'd66535;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_config(random_window(), random_limit(), random_limit(),
                       random_limit(), random_limit());
            add_random_requests(PHASE_ITEMS);
            drain();
        end

        repeat (6) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
